// File: rtl/frcd_pkg.sv
// ============================================================================
// Field ramp calibrated drive: shared package
// Widths, calibration coefficient tables, phase and sequencer codes, and the
// command and response structures passed between the ramp control and the
// calibration unit.
// ============================================================================
package frcd_pkg;

   // Field and register widths
   localparam int FIELD_W     = 24;
   localparam int STEP_W      = 21;
   localparam int TICKS_W     = 16;
   localparam int VOLTS_W     = 21;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 1;

   // Serial multiplier operand widths: the multiplicand holds any power of the
   // field up to the fourth, the multiplier holds a field or a coefficient.
   localparam int MCAND_W   = 34;
   localparam int MPLIER_W  = 28;
   localparam int PROD_W    = MCAND_W + MPLIER_W;
   localparam int ACC_W     = PROD_W;
   localparam int MUL_CNT_W = $clog2(MPLIER_W);
   localparam int FRAC_W    = 20;

   // Calibration operation sequence: three powers and four coefficient terms
   localparam int NUM_OPS  = 7;
   localparam int OP_CNT_W = $clog2(NUM_OPS);

   // Reset value of the step register and the output saturation limit
   localparam logic [STEP_W-1:0] RAMP_STEP_RESET = 21'd1049;
   localparam int                VOLT_LIMIT      = 655360;

   // Request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS = 1'b1;

   // Calibration coefficients in Q16, constant term first
   typedef logic signed [MPLIER_W-1:0] coef_type;
   typedef coef_type coef_set_type [5];

   localparam coef_set_type LOW_CAL = '{
      28'sd6821, -28'sd2315125, -28'sd810418, 28'sd3873636, -28'sd81657856
   };
   localparam coef_set_type FIN_CAL = '{
      28'sd1713, -28'sd2294612, 28'sd125377, 28'sd303242, -28'sd1180303
   };

   // Ramp phase
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_RAMP   = 2'd1,
      PH_SETTLE = 2'd2
   } phase_type;

   // Calibration sequencer state
   typedef enum logic [2:0] {
      CS_IDLE   = 3'd0,
      CS_LAUNCH = 3'd1,
      CS_WAIT   = 3'd2,
      CS_FINISH = 3'd3,
      CS_HOLD   = 3'd4
   } cal_state_type;

   // Command from the ramp control to the calibration unit
   typedef struct packed {
      logic               start;
      logic               final_cal;
      logic [FIELD_W-1:0] field;
   } cal_cmd_type;

   // Status and result from the calibration unit
   typedef struct packed {
      logic               busy;
      logic               done;
      logic               final_cal;
      logic [VOLTS_W-1:0] volts;
   } cal_rsp_type;

endpackage

// File: rtl/field_ramp_calibrated_drive_top.sv
// ============================================================================
// Field ramp calibrated drive: top level
// Walks the present field toward a loaded target one step per tick request,
// emitting a calibrated drive voltage per step and a final flagged voltage
// after the settle count has elapsed.
// ============================================================================
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+--------------------------------
//   req     | in        | req_valid/req_stall | req_opcode, req_target_field
//   rsp     | out       | rsp_valid/rsp_stall | rsp_drive_volts, rsp_is_final
//   csr     | in        | csr_write           | csr_index, csr_wdata
//
// A tick that produces a voltage holds the calibration unit for seven products
// on the serial multiplier, then for rounding and handover.
// Reset is synchronous.
// A finished voltage waits in the output register while rsp_stall is high;
// requests are stalled while the calibration unit computes or holds a voltage.
//
module field_ramp_calibrated_drive_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic signed [frcd_pkg::FIELD_W-1:0] req_target_field,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [frcd_pkg::VOLTS_W-1:0] rsp_drive_volts,
   output logic                             rsp_is_final,
   input  logic                             csr_write,
   input  logic [frcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [frcd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import frcd_pkg::*;

   logic [STEP_W-1:0]  ramp_step_ff, ramp_step_in;
   logic [TICKS_W-1:0] settle_ticks_ff, settle_ticks_in;
   logic [FIELD_W-1:0] present_ff, present_in;
   logic [FIELD_W-1:0] goal_ff, goal_in;
   phase_type          phase_ff, phase_in;
   logic [TICKS_W-1:0] wait_ff, wait_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VOLTS_W-1:0] rsp_volts_ff, rsp_volts_in;
   logic               rsp_final_ff, rsp_final_in;

   cal_cmd_type        cal_cmd;
   cal_rsp_type        cal_rsp;
   logic               accept;
   logic               take;
   logic [STEP_W-1:0]  step;
   logic [FIELD_W:0]   gap;
   logic [FIELD_W:0]   mag;
   logic               far;
   logic [FIELD_W-1:0] stepped;
   logic [TICKS_W-1:0] count;
   logic               settle;

   frcd_calib u_calib (
      .clock (clock),
      .reset (reset),
      .cmd   (cal_cmd),
      .take  (take),
      .rsp   (cal_rsp)
   );

   // Requests wait while the calibration unit is in use.
   assign req_stall = cal_rsp.busy;
   assign accept    = req_valid && !req_stall;

   // Gap to the goal and the candidate next field; a zero step acts as one.
   always_comb begin
      step    = (ramp_step_ff == '0) ? STEP_W'(1) : ramp_step_ff;
      gap     = {goal_ff[FIELD_W-1], goal_ff} - {present_ff[FIELD_W-1], present_ff};
      mag     = gap[FIELD_W] ? (~gap + (FIELD_W + 1)'(1)) : gap;
      far     = (mag > (FIELD_W + 1)'(step));
      stepped = gap[FIELD_W] ? (present_ff - FIELD_W'(step)) : (present_ff + FIELD_W'(step));
   end

   // Ramp control: load, step, settle count and final snap.
   always_comb begin
      present_in        = present_ff;
      goal_in           = goal_ff;
      phase_in          = phase_ff;
      wait_in           = wait_ff;
      cal_cmd.start     = 1'b0;
      cal_cmd.final_cal = 1'b0;
      cal_cmd.field     = present_ff;
      count             = wait_ff;
      settle            = 1'b0;

      if (accept) begin
         if (req_opcode == OP_LOAD) begin
            goal_in  = req_target_field;
            phase_in = PH_RAMP;
         end else begin
            case (phase_ff)
               PH_RAMP: begin
                  if (far) begin
                     present_in    = stepped;
                     cal_cmd.start = 1'b1;
                     cal_cmd.field = stepped;
                  end else begin
                     count  = settle_ticks_ff;
                     settle = 1'b1;
                  end
               end
               PH_SETTLE: begin
                  settle = 1'b1;
               end
               default: begin
                  settle = 1'b0;
               end
            endcase
         end
      end

      // Settling tick: count down, or snap to the goal and issue the final write.
      if (settle) begin
         if (count == '0) begin
            present_in        = goal_ff;
            phase_in          = PH_IDLE;
            cal_cmd.start     = 1'b1;
            cal_cmd.final_cal = 1'b1;
            cal_cmd.field     = goal_ff;
         end else begin
            wait_in  = count - TICKS_W'(1);
            phase_in = PH_SETTLE;
         end
      end
   end

   // Configuration writes.
   always_comb begin
      ramp_step_in    = ramp_step_ff;
      settle_ticks_in = settle_ticks_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RAMP_STEP: begin
               ramp_step_in = csr_wdata[STEP_W-1:0];
            end
            CSR_SETTLE_TICKS: begin
               settle_ticks_in = csr_wdata[TICKS_W-1:0];
            end
            default: begin
               ramp_step_in = ramp_step_ff;
            end
         endcase
      end
   end

   // Output register: takes a finished voltage whenever it is free.
   always_comb begin
      take         = cal_rsp.done && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      rsp_volts_in = rsp_volts_ff;
      rsp_final_in = rsp_final_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_volts_in = cal_rsp.volts;
         rsp_final_in = cal_rsp.final_cal;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff    <= RAMP_STEP_RESET;
         settle_ticks_ff <= '0;
         present_ff      <= '0;
         goal_ff         <= '0;
         phase_ff        <= PH_IDLE;
         wait_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         ramp_step_ff    <= ramp_step_in;
         settle_ticks_ff <= settle_ticks_in;
         present_ff      <= present_in;
         goal_ff         <= goal_in;
         phase_ff        <= phase_in;
         wait_ff         <= wait_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_volts_ff <= rsp_volts_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_volts = rsp_volts_ff;
   assign rsp_is_final    = rsp_final_ff;

endmodule

// File: rtl/frcd_serial_mul.sv
// ============================================================================
// Field ramp calibrated drive: bit-serial multiplier
// Signed shift-add multiplier retiring one multiplier bit per cycle. The
// multiplier bits shift out of the low half of the product register while
// the partial sum shifts in from the high half.
// ============================================================================
module frcd_serial_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [frcd_pkg::MCAND_W-1:0]  mcand,
   input  logic [frcd_pkg::MPLIER_W-1:0] mplier,
   output logic                          done,
   output logic [frcd_pkg::PROD_W-1:0]   product
);
   import frcd_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MCAND_W-1:0]   mcand_ff, mcand_in;
   logic [MCAND_W:0]     hi_ff, hi_in;
   logic [MPLIER_W-1:0]  lo_ff, lo_in;

   logic                 last_step;
   logic [MCAND_W:0]     mcand_ext;
   logic [MCAND_W:0]     addend;
   logic [MCAND_W:0]     sum;

   // One shift-add step; the top multiplier bit carries negative weight.
   always_comb begin
      last_step = (cnt_ff == MUL_CNT_W'(MPLIER_W - 1));
      mcand_ext = {mcand_ff[MCAND_W-1], mcand_ff};
      addend    = '0;
      if (lo_ff[0]) begin
         addend = last_step ? (~mcand_ext + (MCAND_W + 1)'(1)) : mcand_ext;
      end
      sum = hi_ff + addend;

      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;

      if (run_ff) begin
         hi_in  = {sum[MCAND_W], sum[MCAND_W:1]};
         lo_in  = {sum[0], lo_ff[MPLIER_W-1:1]};
         cnt_in = cnt_ff + MUL_CNT_W'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
      end
   end

   // Control state is reset; the operand and product registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff[MCAND_W-1:0], lo_ff};

endmodule

// File: rtl/frcd_calib.sv
// ============================================================================
// Field ramp calibrated drive: polynomial calibration unit
// Evaluates a quartic calibration of the field with one shared serial
// multiplier: three power products rounded to Q20 and four coefficient
// products summed in Q36, then rounds to Q16 and saturates to +/-10 V.
// ============================================================================
module frcd_calib (
   input  logic                  clock,
   input  logic                  reset,
   input  frcd_pkg::cal_cmd_type cmd,
   input  logic                  take,
   output frcd_pkg::cal_rsp_type rsp
);
   import frcd_pkg::*;

   localparam int RND_W = ACC_W - FRAC_W;
   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(VOLT_LIMIT);
   localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI;
   localparam logic [PROD_W-1:0]       HALF   = PROD_W'(1) << (FRAC_W - 1);

   cal_state_type       state_ff, state_in;
   logic [OP_CNT_W-1:0] op_ff, op_in;
   logic                fin_ff, fin_in;
   logic [FIELD_W-1:0]  field_ff, field_in;
   logic [MCAND_W-1:0]  pw_ff, pw_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [VOLTS_W-1:0]  volts_ff, volts_in;

   logic                mul_start;
   logic                mul_done;
   logic [PROD_W-1:0]   product;
   logic [MCAND_W-1:0]  mcand;
   logic [MPLIER_W-1:0] mplier;
   logic                is_power;
   logic [MCAND_W-1:0]  field_m;
   logic [MPLIER_W-1:0] field_q;
   coef_type            c0;
   logic [PROD_W-1:0]   prod_biased;
   logic [ACC_W-1:0]    acc_biased;
   logic signed [RND_W-1:0] rounded;

   frcd_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mcand),
      .mplier  (mplier),
      .done    (mul_done),
      .product (product)
   );

   // Operand selection for each step of the sequence.
   always_comb begin
      field_m  = {{(MCAND_W - FIELD_W){field_ff[FIELD_W-1]}}, field_ff};
      field_q  = {{(MPLIER_W - FIELD_W){field_ff[FIELD_W-1]}}, field_ff};
      mcand    = pw_ff;
      mplier   = field_q;
      is_power = 1'b1;
      case (op_ff)
         3'd0: begin
            mcand = field_m;
         end
         3'd1: begin
            mcand    = field_m;
            mplier   = fin_ff ? FIN_CAL[1] : LOW_CAL[1];
            is_power = 1'b0;
         end
         3'd2: begin
            mplier   = fin_ff ? FIN_CAL[2] : LOW_CAL[2];
            is_power = 1'b0;
         end
         3'd4: begin
            mplier   = fin_ff ? FIN_CAL[3] : LOW_CAL[3];
            is_power = 1'b0;
         end
         3'd6: begin
            mplier   = fin_ff ? FIN_CAL[4] : LOW_CAL[4];
            is_power = 1'b0;
         end
         default: begin
            mcand = pw_ff;
         end
      endcase
   end

   // Rounding of a power product and of the final sum, half up.
   always_comb begin
      prod_biased = product + HALF;
      acc_biased  = acc_ff + HALF;
      rounded     = acc_biased[ACC_W-1:FRAC_W];
   end

   // Sequencer: next state and outputs.
   always_comb begin
      c0        = cmd.final_cal ? FIN_CAL[0] : LOW_CAL[0];
      state_in  = state_ff;
      op_in     = op_ff;
      fin_in    = fin_ff;
      field_in  = field_ff;
      pw_in     = pw_ff;
      acc_in    = acc_ff;
      volts_in  = volts_ff;
      mul_start = 1'b0;

      case (state_ff)
         CS_IDLE: begin
            if (cmd.start) begin
               field_in = cmd.field;
               fin_in   = cmd.final_cal;
               acc_in   = {{(ACC_W - MPLIER_W){c0[MPLIER_W-1]}}, c0} << FRAC_W;
               op_in    = '0;
               state_in = CS_LAUNCH;
            end
         end
         CS_LAUNCH: begin
            mul_start = 1'b1;
            state_in  = CS_WAIT;
         end
         CS_WAIT: begin
            if (mul_done) begin
               if (is_power) begin
                  pw_in = prod_biased[FRAC_W +: MCAND_W];
               end else begin
                  acc_in = acc_ff + product;
               end
               if (op_ff == OP_CNT_W'(NUM_OPS - 1)) begin
                  state_in = CS_FINISH;
               end else begin
                  op_in    = op_ff + OP_CNT_W'(1);
                  state_in = CS_LAUNCH;
               end
            end
         end
         CS_FINISH: begin
            if (rounded > SAT_HI) begin
               volts_in = SAT_HI[VOLTS_W-1:0];
            end else if (rounded < SAT_LO) begin
               volts_in = SAT_LO[VOLTS_W-1:0];
            end else begin
               volts_in = rounded[VOLTS_W-1:0];
            end
            state_in = CS_HOLD;
         end
         CS_HOLD: begin
            if (take) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase

      rsp.busy      = (state_ff != CS_IDLE);
      rsp.done      = (state_ff == CS_HOLD);
      rsp.final_cal = fin_ff;
      rsp.volts     = volts_ff;
   end

   // State register; datapath registers carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
      fin_ff   <= fin_in;
      field_ff <= field_in;
      pw_ff    <= pw_in;
      acc_ff   <= acc_in;
      volts_ff <= volts_in;
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Field ramp calibrated drive: self-checking testbench
// Drives load and tick requests through the valid/stall request channel,
// predicts every calibrated drive voltage with an independent fixed-point
// calculation, and checks each accepted response field by field in order.
// Both sides idle at random; the response side also holds off for a long
// stretch so that the block backs up and stalls its request channel.
// ============================================================================
module tb_top;
   import frcd_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int ITEM_TARGET   = 1750;
   localparam int SETTLE_GUARD  = 300;
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 2000;
   localparam int QUIET_FROM    = 700;
   localparam int QUIET_TO      = 1000;
   localparam int TIMEOUT_NS    = 40_000_000;
   localparam int MAX_STEP      = 1048576;
   localparam int MAX_TICKS     = 65535;

   // One expected response
   typedef struct {
      logic signed [VOLTS_W-1:0] volts;
      logic                      is_final;
   } volts_item_type;

   // Tracks the ramp state and holds the voltages still to come
   class field_ramp_tracker;
      volts_item_type            pending_volts[$];
      logic [STEP_W-1:0]         ramp_step;
      logic [TICKS_W-1:0]        settle_ticks;
      logic signed [FIELD_W-1:0] present;
      logic signed [FIELD_W-1:0] goal;
      phase_type                 ph;
      logic [TICKS_W-1:0]        wait_left;
      int                        fault_count;

      function new();
         ramp_step    = RAMP_STEP_RESET;
         settle_ticks = '0;
         present      = '0;
         goal         = '0;
         ph           = PH_IDLE;
         wait_left    = '0;
         fault_count  = 0;
      endfunction

      function int pending();
         return pending_volts.size();
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
         if (idx == CSR_RAMP_STEP) ramp_step = value[STEP_W-1:0];
         else if (idx == CSR_SETTLE_TICKS) settle_ticks = value[TICKS_W-1:0];
      endfunction

      // Arithmetic shift by 20 with rounding half towards plus infinity
      function longint round_q20(longint v);
         return (v + (longint'(1) <<< 19)) >>> 20;
      endfunction

      // Quartic calibration of a Q3.20 field into saturated Q4.16 volts
      function logic signed [VOLTS_W-1:0] cal_volts(logic signed [FIELD_W-1:0] f,
                                                      bit final_set);
         longint coef [5];
         longint x, x2, x3, x4, acc, v;
         if (final_set) begin
            coef = '{1713, -2294612, 125377, 303242, -1180303};
         end else begin
            coef = '{6821, -2315125, -810418, 3873636, -81657856};
         end
         x   = f;
         x2  = round_q20(x * x);
         x3  = round_q20(x2 * x);
         x4  = round_q20(x3 * x);
         acc = coef[0] * 1048576 + coef[1] * x + coef[2] * x2 + coef[3] * x3
               + coef[4] * x4;
         v   = round_q20(acc);
         if (v > VOLT_LIMIT) v = VOLT_LIMIT;
         if (v < -VOLT_LIMIT) v = -VOLT_LIMIT;
         return v[VOLTS_W-1:0];
      endfunction

      function void expect_volts(bit final_set);
         volts_item_type item;
         item.volts    = cal_volts(present, final_set);
         item.is_final = final_set;
         pending_volts.push_back(item);
      endfunction

      // Advance the ramp for one accepted request
      function void take_request(logic op, logic signed [FIELD_W-1:0] fld);
         longint step, gap, mag;
         if (op == OP_LOAD) begin
            goal = fld;
            ph   = PH_RAMP;
            return;
         end
         if (ph == PH_RAMP) begin
            step = (ramp_step == 0) ? 1 : longint'(ramp_step);
            gap  = longint'(goal) - longint'(present);
            mag  = (gap < 0) ? -gap : gap;
            if (mag > step) begin
               present = present + ((gap < 0) ? -step : step);
               expect_volts(1'b0);
               return;
            end
            wait_left = settle_ticks;
            ph        = PH_SETTLE;
         end
         if (ph == PH_SETTLE) begin
            if (wait_left == 0) begin
               present = goal;
               ph      = PH_IDLE;
               expect_volts(1'b1);
            end else begin
               wait_left = wait_left - 1'b1;
            end
         end
      endfunction

      task report(string what);
         $display("tb_top mismatch at %0t: %s", $realtime, what);
         fault_count++;
      endtask

      // Compare one accepted response with the oldest expected voltage
      task check_volts(logic signed [VOLTS_W-1:0] volts, logic fin);
         volts_item_type want;
         if (pending_volts.size() == 0) begin
            report($sformatf("response with nothing expected: volts %0d final %0b",
                             volts, fin));
            return;
         end
         want = pending_volts.pop_front();
         if (volts !== want.volts)
            report($sformatf("drive_volts %0d, expected %0d", volts, want.volts));
         if (fin !== want.is_final)
            report($sformatf("is_final %0b, expected %0b", fin, want.is_final));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_opcode = OP_TICK;
   logic signed [FIELD_W-1:0] req_target_field = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VOLTS_W-1:0] rsp_drive_volts;
   logic                      rsp_is_final;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_RAMP_STEP;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   logic                      quiet = 1'b0;
   int                        items_sent = 0;
   longint                    last_goal = 0;
   field_ramp_tracker         book = new();

   field_ramp_calibrated_drive_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_target_field (req_target_field),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_volts  (rsp_drive_volts),
      .rsp_is_final     (rsp_is_final),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #TIMEOUT_NS;
      $display("tb_top: errors");
      $finish;
   end

   // Observe both handshakes on the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.take_request(req_opcode, req_target_field);
         if (rsp_valid && !rsp_stall) book.check_volts(rsp_drive_volts, rsp_is_final);
      end
   end

   // Response side: random stalls, one long hold-off, none in the quiet stretch
   int rsp_seen  = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_seen++;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 8);
      end
   end

   // Offer one request and wait for its acceptance, then perhaps pause
   task automatic send_request(input logic op, input logic signed [FIELD_W-1:0] fld);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_target_field <= fld;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(OP_TICK, FIELD_W'($urandom));
   endtask

   // Wait until every expected voltage has come and the block has gone quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (book.pending() != 0);
      repeat (SETTLE_GUARD) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      book.set_register(idx, value);
   endtask

   // A load towards a nearby goal followed by ticks: mostly enough to finish
   // the ramp and the settle count, sometimes cut short by the next load.
   task automatic ramp_sequence(input int unsigned step_val, input int unsigned settle_val);
      longint unsigned eff_step;
      longint          tgt;
      int              k;
      int              ticks;
      eff_step = (step_val == 0) ? 1 : step_val;
      k        = $urandom_range(0, 24);
      if ($urandom_range(9) == 0) begin
         tgt = longint'($signed(FIELD_W'($urandom)));
      end else begin
         tgt = longint'(k) * longint'(eff_step) + longint'($urandom_range(0, eff_step));
         tgt = $urandom_range(1) ? last_goal + tgt : last_goal - tgt;
      end
      if (tgt > 8388607) tgt = 8388607;
      if (tgt < -8388608) tgt = -8388608;
      send_request(OP_LOAD, tgt[FIELD_W-1:0]);
      last_goal = tgt;
      if (settle_val > 40) ticks = k + $urandom_range(0, 20);
      else if ($urandom_range(3) == 0) ticks = $urandom_range(0, k);
      else ticks = k + settle_val + 1 + $urandom_range(0, 2);
      send_ticks(ticks);
   endtask

   // Stray requests of either kind with any content
   task automatic noise_sequence();
      repeat ($urandom_range(1, 6)) begin
         send_request($urandom_range(1) ? OP_TICK : OP_LOAD, FIELD_W'($urandom));
      end
   endtask

   // Main stimulus
   initial begin
      int unsigned step_val;
      int unsigned settle_val;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset: two steps, the final write, then a tick while idle
      send_request(OP_LOAD, 24'sd3000);
      send_ticks(4);
      last_goal = 3000;

      // Largest step towards both ends of the field range
      wait_idle();
      write_register(CSR_RAMP_STEP, MAX_STEP);
      write_register(CSR_SETTLE_TICKS, 0);
      send_request(OP_LOAD, 24'sd8388607);
      send_ticks(8);
      send_request(OP_LOAD, -24'sd8388608);
      send_ticks(3);

      // Zero step acts as one; a load in mid-ramp restarts it; settle count of two
      wait_idle();
      write_register(CSR_RAMP_STEP, 0);
      write_register(CSR_SETTLE_TICKS, 2);
      send_request(OP_LOAD, 24'sd5242882);
      send_ticks(5);
      last_goal = 5242882;

      // Random phases, each under its own register settings
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case ($urandom_range(5))
            0:       step_val = 1;
            1:       step_val = MAX_STEP;
            2:       step_val = 0;
            3, 4:    step_val = $urandom_range(1, 4096);
            default: step_val = $urandom_range(1, MAX_STEP);
         endcase
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: settle_val = 0;
            17:                     settle_val = MAX_TICKS;
            18:                     settle_val = $urandom_range(0, MAX_TICKS);
            default:                settle_val = $urandom_range(1, 4);
         endcase
         write_register(CSR_RAMP_STEP, step_val);
         write_register(CSR_SETTLE_TICKS, settle_val);
         repeat ($urandom_range(5, 10)) begin
            if (items_sent < ITEM_TARGET) begin
               quiet <= (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
               if ($urandom_range(9) == 0) noise_sequence();
               else ramp_sequence(step_val, settle_val);
            end
         end
      end

      wait_idle();
      if (book.fault_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

// File: files.f
rtl/frcd_pkg.sv
rtl/frcd_serial_mul.sv
rtl/frcd_calib.sv
rtl/field_ramp_calibrated_drive_top.sv
tb/tb_top.sv
